// ===== sv/tsmq_pkg.sv =====
// ----------------------------------------------------------------------------
// tsmq_pkg
// Shared constants and types for the thread scheduler with mutex wait lists.
// ----------------------------------------------------------------------------
package tsmq_pkg;

  localparam int SLOT_COUNT_DEF  = 128;
  localparam int MUTEX_COUNT_DEF = 16;

  localparam int OP_W  = 3;
  localparam int MID_W = 4;
  localparam int TID_W = 7;
  localparam int VAL_W = 64;
  localparam int RC_W  = 3;

  // ready slots examined per scan cycle
  localparam int SCAN_W = 16;
  localparam int OFS_W  = $clog2(SCAN_W);

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
  localparam logic [OP_W-1:0] OP_EXIT   = 3'd2;
  localparam logic [OP_W-1:0] OP_JOIN   = 3'd3;
  localparam logic [OP_W-1:0] OP_LOCK   = 3'd4;
  localparam logic [OP_W-1:0] OP_UNLOCK = 3'd5;

  localparam logic [RC_W-1:0] RC_OK         = 3'd0;
  localparam logic [RC_W-1:0] RC_BLOCKED    = 3'd1;
  localparam logic [RC_W-1:0] RC_FULL       = 3'd2;
  localparam logic [RC_W-1:0] RC_NOT_EXITED = 3'd3;
  localparam logic [RC_W-1:0] RC_NO_READY   = 3'd4;

  typedef struct packed {
    logic             hit;
    logic [OFS_W-1:0] off;
  } scan_res_t;

endpackage

// ===== sv/thread_scheduler_with_mutex_queues_top.sv =====
// ----------------------------------------------------------------------------
// thread_scheduler_with_mutex_queues_top
// Round-robin thread slot manager with FIFO wait lists per mutex.
// ----------------------------------------------------------------------------
// One event item is taken when start is high and busy is low. Create, a
// successful join, a free lock or an unlock with no waiter go from the read
// step straight to the finish step. An event that schedules passes through
// the read, prepare, scan and finish steps, with a link step after the read
// for an unlock that must follow the wait list link. The round-robin search
// looks at 16 ready flags per cycle starting after the current slot, until
// it finds one ready or has wrapped round. The result item appears for one
// cycle with done, in the first cycle that busy is low, and must be taken
// then: the receiver cannot stall the block.
// ----------------------------------------------------------------------------
module thread_scheduler_with_mutex_queues_top #(
  parameter int SLOT_COUNT  = tsmq_pkg::SLOT_COUNT_DEF,
  parameter int MUTEX_COUNT = tsmq_pkg::MUTEX_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tsmq_pkg::OP_W-1:0]   opcode,
  input  logic [tsmq_pkg::MID_W-1:0]  mutex_id,
  input  logic [tsmq_pkg::TID_W-1:0]  target_thread,
  input  logic [tsmq_pkg::VAL_W-1:0]  exit_value,
  output logic                        done,
  output logic [tsmq_pkg::TID_W-1:0]  running_thread,
  output logic [tsmq_pkg::RC_W-1:0]   result_code,
  output logic [tsmq_pkg::TID_W-1:0]  new_thread_id,
  output logic [tsmq_pkg::VAL_W-1:0]  exit_result,
  output logic                        idle
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int MUT_W  = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int NCH    = (SLOT_COUNT + tsmq_pkg::SCAN_W - 1) / tsmq_pkg::SCAN_W;
  localparam int CHW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int GW     = CHW + tsmq_pkg::OFS_W;
  localparam int PAD_W  = NCH * tsmq_pkg::SCAN_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_LINK = 6'b000100,
    S_PREP = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;

  logic [tsmq_pkg::OP_W-1:0]  op_q;
  logic [MUT_W-1:0]           m_q;
  logic                       m_ok_q;
  logic [SLOT_W-1:0]          t_q;
  logic                       t_ok_q;
  logic [tsmq_pkg::VAL_W-1:0] val_q;

  logic [SLOT_W-1:0]          cur;
  logic                       cur_running;
  logic [CNT_W-1:0]           thread_count;
  logic [SLOT_COUNT-1:0]      ready_vec;
  logic [SLOT_COUNT-1:0]      exited_vec;
  logic [MUTEX_COUNT-1:0]     held;
  logic [MUTEX_COUNT-1:0]     nonempty;

  logic [SLOT_W-1:0]          head_mem [MUTEX_COUNT];
  logic [SLOT_W-1:0]          tail_mem [MUTEX_COUNT];
  logic [SLOT_W-1:0]          link_mem [SLOT_COUNT];
  logic [tsmq_pkg::VAL_W-1:0] exit_mem [SLOT_COUNT];

  logic [SLOT_W-1:0]          head_q;
  logic [SLOT_W-1:0]          tail_q;
  logic [SLOT_W-1:0]          link_q;
  logic [tsmq_pkg::VAL_W-1:0] exit_q;

  logic [CHW-1:0]             chunk;
  logic                       upper;
  logic [tsmq_pkg::RC_W-1:0]  code_q;
  logic [tsmq_pkg::TID_W-1:0] newid_q;
  logic [tsmq_pkg::VAL_W-1:0] xres_q;

  logic [GW-1:0]              cur_g;
  logic [CHW-1:0]             cur_chunk;
  logic [PAD_W-1:0]           ready_pad;
  logic [tsmq_pkg::SCAN_W-1:0] ready_chunk [NCH];
  tsmq_pkg::scan_res_t        scan;
  logic [SLOT_W-1:0]          hit_idx;

  logic [MUT_W-1:0]           m_addr;
  logic [SLOT_W-1:0]          t_addr;
  logic                       lock_blk;
  logic                       exit_we;
  logic                       head_we;
  logic [SLOT_W-1:0]          head_wdata;
  logic                       link_we;

  assign busy      = (state != S_IDLE);
  assign cur_g     = GW'(cur);
  assign cur_chunk = cur_g[GW-1:tsmq_pkg::OFS_W];
  assign ready_pad = PAD_W'(ready_vec);
  assign hit_idx   = SLOT_W'({chunk, scan.off});
  assign m_addr    = MUT_W'(mutex_id);
  assign t_addr    = SLOT_W'(target_thread);

  for (genvar k = 0; k < NCH; k++) begin : g_chunk
    assign ready_chunk[k] = ready_pad[k*tsmq_pkg::SCAN_W +: tsmq_pkg::SCAN_W];
  end

  tsmq_scan #(
    .CHW (CHW)
  ) u_scan (
    .bits  (ready_chunk[chunk]),
    .chunk (chunk),
    .cur_g (cur_g),
    .upper (upper),
    .res   (scan)
  );

  assign lock_blk = (state == S_READ) && (op_q == tsmq_pkg::OP_LOCK) &&
                    m_ok_q && held[m_q];
  assign exit_we  = (state == S_READ) && (op_q == tsmq_pkg::OP_EXIT);
  assign link_we  = lock_blk && nonempty[m_q];

  always_comb begin
    head_we    = 1'b0;
    head_wdata = cur;
    if (lock_blk && !nonempty[m_q]) begin
      head_we = 1'b1;
    end else if (state == S_LINK) begin
      head_we    = 1'b1;
      head_wdata = link_q;
    end
  end

  // wait list and exit value stores
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[m_q] <= head_wdata;
    end
    if (lock_blk) begin
      tail_mem[m_q] <= cur;
    end
    if (link_we) begin
      link_mem[tail_q] <= cur;
    end
    if (exit_we) begin
      exit_mem[cur] <= val_q;
    end
    if (state == S_IDLE) begin
      head_q <= head_mem[m_addr];
      tail_q <= tail_mem[m_addr];
      exit_q <= exit_mem[t_addr];
    end
    link_q <= link_mem[head_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur          <= '0;
      cur_running  <= 1'b1;
      thread_count <= CNT_W'(1);
      ready_vec    <= '0;
      exited_vec   <= '0;
      held         <= '0;
      nonempty     <= '0;
      done         <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q    <= (cur_running || opcode == tsmq_pkg::OP_CREATE) ?
                       opcode : tsmq_pkg::OP_TICK;
            m_q     <= m_addr;
            m_ok_q  <= 32'(mutex_id) < 32'(MUTEX_COUNT);
            t_q     <= t_addr;
            t_ok_q  <= 32'(target_thread) < 32'(SLOT_COUNT);
            val_q   <= exit_value;
            code_q  <= tsmq_pkg::RC_OK;
            newid_q <= '0;
            xres_q  <= '0;
            state   <= S_READ;
          end
        end
        S_READ: begin
          case (op_q)
            tsmq_pkg::OP_CREATE: begin
              if (thread_count < CNT_W'(SLOT_COUNT)) begin
                ready_vec[thread_count[SLOT_W-1:0]] <= 1'b1;
                thread_count <= thread_count + CNT_W'(1);
                newid_q      <= tsmq_pkg::TID_W'(thread_count);
              end else begin
                code_q <= tsmq_pkg::RC_FULL;
              end
              state <= S_DONE;
            end
            tsmq_pkg::OP_EXIT: begin
              exited_vec[cur] <= 1'b1;
              cur_running     <= 1'b0;
              state           <= S_PREP;
            end
            tsmq_pkg::OP_JOIN: begin
              if (t_ok_q && exited_vec[t_q]) begin
                xres_q <= exit_q;
                state  <= S_DONE;
              end else begin
                code_q <= tsmq_pkg::RC_NOT_EXITED;
                state  <= S_PREP;
              end
            end
            tsmq_pkg::OP_LOCK: begin
              if (!m_ok_q) begin
                state <= S_DONE;
              end else if (!held[m_q]) begin
                held[m_q] <= 1'b1;
                state     <= S_DONE;
              end else begin
                cur_running   <= 1'b0;
                nonempty[m_q] <= 1'b1;
                code_q        <= tsmq_pkg::RC_BLOCKED;
                state         <= S_PREP;
              end
            end
            tsmq_pkg::OP_UNLOCK: begin
              if (!m_ok_q) begin
                state <= S_DONE;
              end else if (!nonempty[m_q]) begin
                held[m_q] <= 1'b0;
                state     <= S_DONE;
              end else begin
                ready_vec[head_q] <= 1'b1;
                if (head_q == tail_q) begin
                  nonempty[m_q] <= 1'b0;
                  state         <= S_PREP;
                end else begin
                  state <= S_LINK;
                end
              end
            end
            default: begin
              state <= S_PREP;
            end
          endcase
        end
        S_LINK: begin
          state <= S_PREP;
        end
        S_PREP: begin
          if (cur_running) begin
            ready_vec[cur] <= 1'b1;
          end
          cur_running <= 1'b0;
          chunk       <= cur_chunk;
          upper       <= 1'b1;
          state       <= S_SCAN;
        end
        S_SCAN: begin
          if (scan.hit) begin
            cur                <= hit_idx;
            ready_vec[hit_idx] <= 1'b0;
            cur_running        <= 1'b1;
            state              <= S_DONE;
          end else if (upper) begin
            if (chunk == CHW'(NCH - 1)) begin
              upper <= 1'b0;
              chunk <= '0;
            end else begin
              chunk <= chunk + CHW'(1);
            end
          end else if (chunk == cur_chunk) begin
            state <= S_DONE;
          end else begin
            chunk <= chunk + CHW'(1);
          end
        end
        S_DONE: begin
          running_thread <= tsmq_pkg::TID_W'(cur);
          idle           <= !cur_running;
          result_code    <= (!cur_running && code_q != tsmq_pkg::RC_BLOCKED &&
                             code_q != tsmq_pkg::RC_FULL) ?
                            tsmq_pkg::RC_NO_READY : code_q;
          new_thread_id  <= newid_q;
          exit_result    <= xres_q;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_from_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE))
    else $error("result strobe without a finishing step");

  a_running_not_ready: assert property (@(posedge clk) disable iff (rst)
    cur_running |-> !ready_vec[cur])
    else $error("running slot also flagged ready");

  a_exited_not_ready: assert property (@(posedge clk) disable iff (rst)
    (ready_vec & exited_vec) == '0)
    else $error("exited slot flagged ready");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    thread_count != '0 && thread_count <= CNT_W'(SLOT_COUNT))
    else $error("thread count out of range");

  a_idle_code: assert property (@(posedge clk) disable iff (rst)
    (done && idle) |-> (result_code == tsmq_pkg::RC_NO_READY ||
                        result_code == tsmq_pkg::RC_BLOCKED ||
                        result_code == tsmq_pkg::RC_FULL))
    else $error("idle result with wrong code");

endmodule

// ===== sv/tsmq_scan.sv =====
// ----------------------------------------------------------------------------
// tsmq_scan
// Masked priority search over one chunk of ready flags for round-robin pick.
// ----------------------------------------------------------------------------
module tsmq_scan #(
  parameter int CHW = 3
) (
  input  logic [tsmq_pkg::SCAN_W-1:0]   bits,
  input  logic [CHW-1:0]                chunk,
  input  logic [CHW+tsmq_pkg::OFS_W-1:0] cur_g,
  input  logic                          upper,
  output tsmq_pkg::scan_res_t           res
);

  localparam int GW = CHW + tsmq_pkg::OFS_W;

  logic [tsmq_pkg::SCAN_W-1:0] masked;

  // upper pass: slots above current; wrap pass: current and below
  always_comb begin
    logic [GW-1:0] g;
    for (int i = 0; i < tsmq_pkg::SCAN_W; i++) begin
      g = {chunk, tsmq_pkg::OFS_W'(i)};
      masked[i] = bits[i] && (upper ? (g > cur_g) : (g <= cur_g));
    end
  end

  always_comb begin
    res.hit = 1'b0;
    res.off = '0;
    for (int i = tsmq_pkg::SCAN_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        res.hit = 1'b1;
        res.off = tsmq_pkg::OFS_W'(i);
      end
    end
  end

endmodule
